### hdl/mhp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhp_pkg
// shared types and constants of the message header parser
// ---------------------------------------------------------------------------
package mhp_pkg;

  localparam int unsigned MAX_FRAME_BYTES  = 32'd65535;
  localparam int unsigned MAX_VARINT_BYTES = 10;

  localparam int FRAME_CNT_W = 32;
  localparam int VARINT_CNT_W = 4;
  localparam int CODE_CNT_W = 3;
  localparam int CODE_BYTES = 4;
  localparam int PAYLOAD_W = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 136;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_ID    = 3'd1,
    PH_RLEN  = 3'd2,
    PH_ROUTE = 3'd3,
    PH_CODE  = 3'd4,
    PH_BODY  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CLS_HEADER  = 2'd0,
    CLS_ROUTE   = 2'd1,
    CLS_PAYLOAD = 2'd2
  } byte_class_t;

  localparam logic [2:0] KIND_REQUEST  = 3'd0;
  localparam logic [2:0] KIND_NOTIFY   = 3'd1;
  localparam logic [2:0] KIND_RESPONSE = 3'd2;
  localparam logic [2:0] KIND_PUSH     = 3'd3;

  typedef struct packed {
    logic [1:0]         byte_class;
    logic [7:0]         out_byte;
    logic               frame_done;
    logic               status;
    logic [2:0]         msg_type;
    logic [63:0]        msg_id;
    logic [7:0]         route_length;
    logic signed [31:0] response_code;
    logic [15:0]        payload_length;
  } result_t;

endpackage
`default_nettype wire

### hdl/message_header_parser_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// message_header_parser_core
// byte-serial parser for framed messages with a varint id, route and code
// ---------------------------------------------------------------------------
// usage:
//   input stream carries one frame byte per transaction, in_tlast on the
//   final byte. every input transaction produces exactly one output
//   transaction tagging the byte as header, route or payload (out_tuser).
//   the output transaction for the last byte carries out_tlast, status and
//   the decoded header fields; they read as zero on other bytes.
// output: the result of each accepted byte is registered before out_tvalid.
// throughput: one byte per cycle while out_tready is high, with one header
//   state update on each accepted byte.
// reset: rst_n low clears the parser to expect a flag byte and empties the
//   output stage; in_tready is high the cycle after reset is released.
// stall: when out_tready is low, one more byte is taken into a skid
//   register, then in_tready drops until the output drains.
// ---------------------------------------------------------------------------
module message_header_parser_core #(
  parameter int unsigned MAX_FRAME_BYTES  = mhp_pkg::MAX_FRAME_BYTES,
  parameter int unsigned MAX_VARINT_BYTES = mhp_pkg::MAX_VARINT_BYTES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [mhp_pkg::IN_TDATA_W-1:0]    in_tdata,   // data_byte[7:0]
  input  wire logic                              in_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_byte[7:0], status[8], msg_type[11:9], msg_id[75:12],
  // route_length[83:76], response_code[115:84], payload_length[131:116], zero
  output logic [mhp_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic [mhp_pkg::OUT_TUSER_W-1:0]        out_tuser,  // byte_class[1:0]
  output logic                                   out_tlast
);

  logic             step;
  mhp_pkg::result_t step_result;
  mhp_pkg::result_t res;

  assign step = in_tvalid && in_tready;

  mhp_parser #(
    .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .result    (step_result)
  );

  mhp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (step_result),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res)
  );

  assign out_tdata = {4'b0000, res.payload_length, res.response_code, res.route_length,
                      res.msg_id, res.msg_type, res.status, res.out_byte};
  assign out_tuser = res.byte_class;
  assign out_tlast = res.frame_done;

endmodule
`default_nettype wire

### hdl/mhp_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhp_parser
// per-byte header state machine, one state update per accepted byte
// ---------------------------------------------------------------------------
module mhp_parser #(
  parameter int unsigned MAX_FRAME_BYTES  = mhp_pkg::MAX_FRAME_BYTES,
  parameter int unsigned MAX_VARINT_BYTES = mhp_pkg::MAX_VARINT_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output mhp_pkg::result_t     result
);

  mhp_pkg::phase_t                    phase_r, phase_nxt;
  logic [2:0]                         kind_r, kind_nxt;
  logic [63:0]                        id_r, id_nxt;
  logic [mhp_pkg::VARINT_CNT_W-1:0]   vcnt_r, vcnt_nxt;
  logic [7:0]                         rlen_r, rlen_nxt;
  logic [7:0]                         rleft_r, rleft_nxt;
  logic [31:0]                        code_r, code_nxt;
  logic [mhp_pkg::CODE_CNT_W-1:0]     ccnt_r, ccnt_nxt;
  logic [mhp_pkg::PAYLOAD_W-1:0]      pay_r, pay_nxt;
  logic                               err_r, err_nxt;
  logic [mhp_pkg::FRAME_CNT_W-1:0]    fcnt_r, fcnt_nxt;

  logic                               fail;
  logic [6:0]                         id_shamt;
  logic [63:0]                        id_part;
  logic [4:0]                         code_shamt;
  logic [31:0]                        code_part;
  logic                               is_bad;

  assign id_shamt   = 7'(vcnt_r) * 7'd7;
  assign id_part    = 64'(data_byte[6:0]) << id_shamt;
  assign code_shamt = {ccnt_r[1:0], 3'b000};
  assign code_part  = 32'(data_byte) << code_shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mhp_pkg::PH_FLAG;
      kind_r  <= '0;
      id_r    <= '0;
      vcnt_r  <= '0;
      rlen_r  <= '0;
      rleft_r <= '0;
      code_r  <= '0;
      ccnt_r  <= '0;
      pay_r   <= '0;
      err_r   <= 1'b0;
      fcnt_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      id_r    <= id_nxt;
      vcnt_r  <= vcnt_nxt;
      rlen_r  <= rlen_nxt;
      rleft_r <= rleft_nxt;
      code_r  <= code_nxt;
      ccnt_r  <= ccnt_nxt;
      pay_r   <= pay_nxt;
      err_r   <= err_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    id_nxt    = id_r;
    vcnt_nxt  = vcnt_r;
    rlen_nxt  = rlen_r;
    rleft_nxt = rleft_r;
    code_nxt  = code_r;
    ccnt_nxt  = ccnt_r;
    pay_nxt   = pay_r;
    err_nxt   = err_r;
    fail      = 1'b0;
    result    = '0;
    result.byte_class = mhp_pkg::CLS_HEADER;
    fcnt_nxt  = (fcnt_r != '1) ? fcnt_r + 1'b1 : fcnt_r;

    unique case (phase_r)
      mhp_pkg::PH_FLAG: begin
        kind_nxt = data_byte[3:1];
        if (kind_nxt[2]) begin
          fail = 1'b1;
        end else if (kind_nxt == mhp_pkg::KIND_REQUEST ||
                     kind_nxt == mhp_pkg::KIND_RESPONSE) begin
          vcnt_nxt  = '0;
          phase_nxt = mhp_pkg::PH_ID;
        end else begin
          phase_nxt = mhp_pkg::PH_RLEN;
        end
      end
      mhp_pkg::PH_ID: begin
        id_nxt   = id_r | id_part;
        vcnt_nxt = vcnt_r + 1'b1;
        if (!data_byte[7]) begin
          ccnt_nxt  = '0;
          phase_nxt = (kind_r == mhp_pkg::KIND_REQUEST) ? mhp_pkg::PH_RLEN
                                                        : mhp_pkg::PH_CODE;
        end else if (32'(vcnt_nxt) >= MAX_VARINT_BYTES) begin
          fail = 1'b1;
        end
      end
      mhp_pkg::PH_RLEN: begin
        rlen_nxt  = data_byte;
        rleft_nxt = data_byte;
        phase_nxt = (data_byte != 8'd0) ? mhp_pkg::PH_ROUTE : mhp_pkg::PH_BODY;
      end
      mhp_pkg::PH_ROUTE: begin
        result.byte_class = mhp_pkg::CLS_ROUTE;
        rleft_nxt = rleft_r - 1'b1;
        if (rleft_nxt == 8'd0) begin
          phase_nxt = mhp_pkg::PH_BODY;
        end
      end
      mhp_pkg::PH_CODE: begin
        code_nxt = code_r | code_part;
        ccnt_nxt = ccnt_r + 1'b1;
        if (32'(ccnt_nxt) >= mhp_pkg::CODE_BYTES) begin
          phase_nxt = mhp_pkg::PH_BODY;
        end
      end
      mhp_pkg::PH_BODY: begin
        result.byte_class = mhp_pkg::CLS_PAYLOAD;
        if (pay_r != '1) begin
          pay_nxt = pay_r + 1'b1;
        end
      end
      default: begin
        result.byte_class = mhp_pkg::CLS_HEADER;
      end
    endcase

    if (fcnt_nxt > MAX_FRAME_BYTES) begin
      fail = 1'b1;
    end
    if (fail) begin
      err_nxt   = 1'b1;
      phase_nxt = mhp_pkg::PH_SKIP;
    end

    is_bad = err_nxt || (phase_nxt != mhp_pkg::PH_BODY);

    result.out_byte   = data_byte;
    result.frame_done = last_byte;
    if (last_byte) begin
      result.status = is_bad;
      if (!is_bad) begin
        result.msg_type = kind_nxt;
        if (kind_nxt == mhp_pkg::KIND_REQUEST || kind_nxt == mhp_pkg::KIND_RESPONSE) begin
          result.msg_id = id_nxt;
        end
        if (kind_nxt != mhp_pkg::KIND_RESPONSE) begin
          result.route_length = rlen_nxt;
        end
        if (kind_nxt == mhp_pkg::KIND_RESPONSE) begin
          result.response_code = code_nxt;
        end
        result.payload_length = pay_nxt;
      end
      // frame end returns everything to the start-of-frame state
      phase_nxt = mhp_pkg::PH_FLAG;
      kind_nxt  = '0;
      id_nxt    = '0;
      vcnt_nxt  = '0;
      rlen_nxt  = '0;
      rleft_nxt = '0;
      code_nxt  = '0;
      ccnt_nxt  = '0;
      pay_nxt   = '0;
      err_nxt   = 1'b0;
      fcnt_nxt  = '0;
    end
  end

endmodule
`default_nettype wire

### hdl/mhp_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mhp_out_buf
// result register with a one-entry skid stage
// ---------------------------------------------------------------------------
module mhp_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire mhp_pkg::result_t push_data,
  output logic                  ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output mhp_pkg::result_t      out_data
);

  logic              main_valid_r;
  logic              skid_valid_r;
  mhp_pkg::result_t  main_r;
  mhp_pkg::result_t  skid_r;
  logic              pop;

  assign pop       = main_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// self-checking bench for message_header_parser_core
// ---------------------------------------------------------------------------
// a behavioral parser runs on every accepted input transaction and queues the
// tag it should produce, or the hand-made tag of a typed row; each output
// transaction is compared field by field with the oldest queued tag. a short
// table of hand-made frames comes first, then random frames (mostly well
// formed, some of a bad type, some cut short, some noise). the sender runs in
// bursts with gaps and the receiver stalls on a mode pattern of its own.
// ---------------------------------------------------------------------------
module tb;
  import mhp_pkg::*;

  localparam logic ST_VALID     = 1'b0;
  localparam logic ST_MALFORMED = 1'b1;

  localparam int RX_FREE     = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  localparam int RANDOM_ITEMS   = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam longint RUN_LIMIT  = 64'd200_000;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  // parser state
  phase_t      hdr_phase;
  logic [2:0]  hdr_kind;
  logic [63:0] id_acc;
  logic [3:0]  id_groups;
  logic [7:0]  route_len;
  logic [7:0]  route_rem;
  logic [31:0] code_acc;
  logic [2:0]  code_seen;
  logic [15:0] payload_cnt;
  logic        frame_bad;
  logic [31:0] frame_len;

  result_t     byte_tags_q[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches  = 0;
  int unsigned tag_count   = 0;
  int unsigned burst_left  = 0;
  int unsigned ready_cycle = 0;
  int unsigned ready_mode  = RX_FREE;

  message_header_parser_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_parser();
    hdr_phase   = PH_FLAG;
    hdr_kind    = '0;
    id_acc      = '0;
    id_groups   = '0;
    route_len   = '0;
    route_rem   = '0;
    code_acc    = '0;
    code_seen   = '0;
    payload_cnt = '0;
    frame_bad   = 1'b0;
    frame_len   = '0;
  endfunction

  function automatic void mark_bad();
    frame_bad = 1'b1;
    hdr_phase = PH_SKIP;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic last);
    result_t     r;
    byte_class_t cls;
    int unsigned sh;
    cls = CLS_HEADER;
    if (frame_len != '1) frame_len++;
    case (hdr_phase)
      PH_FLAG: begin
        hdr_kind = b[3:1];
        if (hdr_kind > KIND_PUSH) begin
          mark_bad();
        end else if (hdr_kind == KIND_REQUEST || hdr_kind == KIND_RESPONSE) begin
          id_groups = '0;
          hdr_phase = PH_ID;
        end else begin
          hdr_phase = PH_RLEN;
        end
      end
      PH_ID: begin
        sh = 7 * id_groups;
        if (sh < 64) id_acc |= 64'(b[6:0]) << sh;
        id_groups = id_groups + 4'd1;
        if (!b[7]) begin
          code_seen = '0;
          hdr_phase = (hdr_kind == KIND_REQUEST) ? PH_RLEN : PH_CODE;
        end else if (id_groups >= MAX_VARINT_BYTES) begin
          mark_bad();
        end
      end
      PH_RLEN: begin
        route_len = b;
        route_rem = b;
        hdr_phase = (b != 8'd0) ? PH_ROUTE : PH_BODY;
      end
      PH_ROUTE: begin
        cls = CLS_ROUTE;
        route_rem = route_rem - 8'd1;
        if (route_rem == 8'd0) hdr_phase = PH_BODY;
      end
      PH_CODE: begin
        code_acc |= 32'(b) << ((8 * code_seen) & 31);
        code_seen = code_seen + 3'd1;
        if (code_seen >= CODE_BYTES) hdr_phase = PH_BODY;
      end
      PH_BODY: begin
        cls = CLS_PAYLOAD;
        if (payload_cnt != 16'hffff) payload_cnt++;
      end
      default: cls = CLS_HEADER;
    endcase
    if (frame_len > MAX_FRAME_BYTES) mark_bad();

    r = '0;
    r.byte_class = cls;
    r.out_byte   = b;
    r.frame_done = last;
    if (last) begin
      if (frame_bad || hdr_phase != PH_BODY) begin
        r.status = ST_MALFORMED;
      end else begin
        r.msg_type = hdr_kind;
        if (hdr_kind == KIND_REQUEST || hdr_kind == KIND_RESPONSE) r.msg_id = id_acc;
        if (hdr_kind != KIND_RESPONSE) r.route_length = route_len;
        if (hdr_kind == KIND_RESPONSE) r.response_code = code_acc;
        r.payload_length = payload_cnt;
      end
      clear_parser();
    end
    return r;
  endfunction

  function automatic result_t mk_tag(input byte_class_t cls, input logic [7:0] b,
                                     input logic done, input logic st,
                                     input logic [2:0] kind, input logic [63:0] id,
                                     input logic [7:0] rlen, input logic [31:0] code,
                                     input logic [15:0] plen);
    result_t r;
    r.byte_class     = cls;
    r.out_byte       = b;
    r.frame_done     = done;
    r.status         = st;
    r.msg_type       = kind;
    r.msg_id         = id;
    r.route_length   = rlen;
    r.response_code  = code;
    r.payload_length = plen;
    return r;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic last, input bit typed,
                         input result_t want);
    stim_row_t row;
    row.data  = b;
    row.last  = last;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  task automatic flag_error(input string msg);
    if (mismatches < 100) $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("transaction %0d: %s is %0h, should be %0h",
                           tag_count, name, got, want));
  endtask

  task automatic check_tag();
    result_t want;
    if (byte_tags_q.size() == 0) begin
      flag_error($sformatf("transaction with byte %02h arrived with nothing pending",
                           out_tdata[7:0]));
      return;
    end
    want = byte_tags_q.pop_front();
    tag_count++;
    check_field("byte_class", out_tuser, want.byte_class);
    check_field("out_byte", out_tdata[7:0], want.out_byte);
    check_field("frame_done", out_tlast, want.frame_done);
    check_field("status", out_tdata[8], want.status);
    check_field("msg_type", out_tdata[11:9], want.msg_type);
    check_field("msg_id", out_tdata[75:12], want.msg_id);
    check_field("route_length", out_tdata[83:76], want.route_length);
    check_field("response_code", {32'b0, out_tdata[115:84]}, {32'b0, want.response_code});
    check_field("payload_length", out_tdata[131:116], want.payload_length);
    check_field("tdata padding", out_tdata[OUT_TDATA_W-1:132], '0);
  endtask

  // receiver: stall mode is re-picked at random whenever ready_cycle wraps
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_tag();
    ready_cycle = (ready_cycle + 1) % 200;
    if (ready_cycle == 0) ready_mode = $urandom_range(RX_FREE, RX_PERIODIC);
    case (ready_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default:   out_tready <= (ready_cycle % 5) >= 2;
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                : $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      void'(parse_byte(b, last));
      byte_tags_q.push_back(want);
    end else begin
      byte_tags_q.push_back(parse_byte(b, last));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (byte_tags_q.size() != 0);
  endtask

  initial begin
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [2:0]  kind;
    int unsigned sent;
    int unsigned pick;
    int unsigned style;
    int unsigned n;
    int unsigned cut;

    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // short frame
    add_row(8'h00, 1'b1, 1'b1,
            mk_tag(CLS_HEADER, 8'h00, 1'b1, ST_MALFORMED, '0, '0, '0, '0, '0));
    // invalid type, then a skipped byte
    add_row(8'h0e, 1'b0, 1'b1,
            mk_tag(CLS_HEADER, 8'h0e, 1'b0, ST_VALID, '0, '0, '0, '0, '0));
    add_row(8'hf1, 1'b1, 1'b1,
            mk_tag(CLS_HEADER, 8'hf1, 1'b1, ST_MALFORMED, '0, '0, '0, '0, '0));
    // notify ending on an empty route length
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1,
            mk_tag(CLS_HEADER, 8'h00, 1'b1, ST_VALID, KIND_NOTIFY, '0, '0, '0, '0));
    // response with the most negative code
    add_row(8'h04, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b1,
            mk_tag(CLS_HEADER, 8'h80, 1'b1, ST_VALID, KIND_RESPONSE, '0, '0,
                   32'h8000_0000, '0));
    // varint that never terminates
    add_row(8'h00, 1'b0, 1'b0, '0);
    repeat (MAX_VARINT_BYTES - 1) add_row(8'hff, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b1, 1'b1,
            mk_tag(CLS_HEADER, 8'hff, 1'b1, ST_MALFORMED, '0, '0, '0, '0, '0));
    // push with one route byte and one payload byte
    add_row(8'h06, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'hc3, 1'b0, 1'b0, '0);
    add_row(8'hff, 1'b1, 1'b0, '0);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      frame.delete();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // noise
        n = $urandom_range(1, 6);
        repeat (n) frame.push_back(8'($urandom));
      end else begin
        kind = (pick == 1) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
        b = 8'($urandom);
        b[3:1] = kind;
        frame.push_back(b);
        if (kind == KIND_REQUEST || kind == KIND_RESPONSE) begin
          style = $urandom_range(0, 9);
          if (style == 0) begin
            // all-ones id
            repeat (MAX_VARINT_BYTES - 1) frame.push_back(8'hff);
            frame.push_back(8'h01);
          end else if (style == 2) begin
            frame.push_back(8'h00);
          end else begin
            n = (style == 1) ? MAX_VARINT_BYTES
                             : $urandom_range(1, (style < 8) ? 3 : MAX_VARINT_BYTES);
            for (int i = 0; i < n; i++) begin
              b = 8'($urandom);
              b[7] = (style == 1) || (i != n - 1);
              frame.push_back(b);
            end
          end
        end
        if (kind == KIND_RESPONSE) begin
          if ($urandom_range(0, 7) == 0) begin
            frame.push_back(8'hff);
            frame.push_back(8'hff);
            frame.push_back(8'hff);
            frame.push_back(8'h7f);
          end else begin
            repeat (CODE_BYTES) frame.push_back(8'($urandom));
          end
        end else begin
          n = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 5);
          frame.push_back(8'(n));
          repeat (n) frame.push_back(8'($urandom));
        end
        n = $urandom_range(0, 8);
        repeat (n) frame.push_back(8'($urandom));
        if ($urandom_range(0, 6) == 0) begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) void'(frame.pop_back());
        end
      end
      foreach (frame[i]) begin
        send_byte(frame[i], i == frame.size() - 1, 1'b0, '0);
        sent++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && byte_tags_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
